// File: rtl/lcl_pkg.sv
package lcl_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int DATA_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;
  localparam int STAMP_W   = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_UPDATE
  } lcl_state_t;

  typedef enum logic [1:0] {
    CELL_NOP,
    CELL_FILL,
    CELL_WRITE,
    CELL_RAISE
  } cell_op_t;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_SET = 1'b1
  } action_t;

  typedef struct packed {
    cell_op_t op;
    logic     sel;
  } cell_cmd_t;

endpackage

// File: rtl/lcl_cell.sv
module lcl_cell #(
  parameter int KEY_BITS   = lcl_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS  = lcl_pkg::DATA_BITS_DEF,
  parameter int COUNT_BITS = lcl_pkg::COUNT_BITS_DEF,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [KEY_BITS-1:0]       req_key,
  input  logic [DATA_BITS-1:0]      req_data,
  input  logic [lcl_pkg::STAMP_W-1:0] op_clock,
  input  lcl_pkg::cell_cmd_t        cmd,
  output logic                      match,
  output logic [DATA_BITS-1:0]      rd_data,
  input  logic                      in_has,
  input  logic [COUNT_BITS-1:0]     in_count,
  input  logic [lcl_pkg::STAMP_W-1:0] in_age,
  input  logic [IDX_W-1:0]          in_idx,
  input  logic [KEY_BITS-1:0]       in_key,
  output logic                      out_has,
  output logic [COUNT_BITS-1:0]     out_count,
  output logic [lcl_pkg::STAMP_W-1:0] out_age,
  output logic [IDX_W-1:0]          out_idx,
  output logic [KEY_BITS-1:0]       out_key
);
  import lcl_pkg::*;

  logic                  valid;
  logic [KEY_BITS-1:0]   slot_key;
  logic [DATA_BITS-1:0]  slot_data;
  logic [COUNT_BITS-1:0] use_count;
  logic [STAMP_W-1:0]    count_stamp;
  logic [STAMP_W-1:0]    age;
  logic                  take;
  logic                  at_max;

  assign match   = valid && (slot_key == req_key);
  assign rd_data = match ? slot_data : '0;
  assign age     = op_clock - count_stamp;
  assign at_max  = (use_count == {COUNT_BITS{1'b1}});
  assign take    = valid && (!in_has || (use_count < in_count) ||
                   ((use_count == in_count) && (age > in_age)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.sel && cmd.op == CELL_FILL) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      case (cmd.op)
        CELL_FILL: begin
          slot_key    <= req_key;
          slot_data   <= req_data;
          use_count   <= COUNT_BITS'(1);
          count_stamp <= op_clock;
        end
        CELL_WRITE: begin
          slot_data <= req_data;
          if (!at_max) begin
            use_count   <= use_count + COUNT_BITS'(1);
            count_stamp <= op_clock;
          end
        end
        CELL_RAISE: begin
          if (!at_max) begin
            use_count   <= use_count + COUNT_BITS'(1);
            count_stamp <= op_clock;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // victim candidate moves one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_has <= 1'b0;
    end else begin
      out_has <= in_has || valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_count <= use_count;
      out_age   <= age;
      out_idx   <= IDX_W'(INDEX);
      out_key   <= slot_key;
    end else begin
      out_count <= in_count;
      out_age   <= in_age;
      out_idx   <= in_idx;
      out_key   <= in_key;
    end
  end

endmodule

// File: rtl/lfu_cache_lookup_top.sv
// LFU cache lookup, fully associative, least-frequently-used replacement.
//
// Input channel (in_valid / in_stall): action (0 get, 1 set), key, data_in.
// A transfer happens when in_valid is high and in_stall is low. One request
// is worked at a time; in_stall is high from the cycle after a transfer until
// the request has updated the entries.
// Output channel (out_valid / out_stall): hit, data_out, evicted, evicted_key,
// one result per request, held in an output register while out_stall is
// high. The next request is taken while a result still waits there; the
// request after that waits for the output register to free up.
// Config channel (cfg_valid / cfg_ready, cfg_data): capacity, always ready.
// Gets, set hits and set misses with a free slot go from the look-up state
// to the update state; a set miss that evicts first passes the scan state,
// where the victim search walks the row of entry cells one cell per cycle.
// Reset clears all entries, the operation clock, the occupancy, and sets
// capacity to 16. No clearing pass is needed after reset.
module lfu_cache_lookup_top #(
  parameter int ENTRIES    = lcl_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lcl_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS  = lcl_pkg::DATA_BITS_DEF,
  parameter int COUNT_BITS = lcl_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [KEY_BITS-1:0]        key,
  input  logic [DATA_BITS-1:0]       data_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       hit,
  output logic [DATA_BITS-1:0]       data_out,
  output logic                       evicted,
  output logic [KEY_BITS-1:0]        evicted_key,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lcl_pkg::CAP_W-1:0]  cfg_data
);
  import lcl_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  lcl_state_t state, state_next;

  logic [CAP_W-1:0]     capacity;
  logic [CAP_W-1:0]     cap_eff;
  logic [OCC_W-1:0]     used;
  logic [STAMP_W-1:0]   op_clock;
  logic [IDX_W-1:0]     scan_cnt;

  action_t              req_act;
  logic [KEY_BITS-1:0]  req_key;
  logic [DATA_BITS-1:0] req_data;

  logic                 hit_r;
  logic                 evict_r;
  logic [ENTRIES-1:0]   match_r;
  logic [DATA_BITS-1:0] dout_r;

  logic [ENTRIES-1:0]   match;
  logic [DATA_BITS-1:0] rd_data [ENTRIES];
  logic [DATA_BITS-1:0] rd_any;
  logic                 evict_need;
  logic [ENTRIES-1:0]   sel_vec;
  cell_op_t             cell_op;
  cell_cmd_t            cmd [ENTRIES];
  logic                 in_xfer;
  logic                 upd_go;
  logic                 scan_last;

  logic                  ch_has   [ENTRIES+1];
  logic [COUNT_BITS-1:0] ch_count [ENTRIES+1];
  logic [STAMP_W-1:0]    ch_age   [ENTRIES+1];
  logic [IDX_W-1:0]      ch_idx   [ENTRIES+1];
  logic [KEY_BITS-1:0]   ch_key   [ENTRIES+1];

  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign scan_last = (scan_cnt == IDX_W'(ENTRIES - 1));

  assign ch_has[0]   = 1'b0;
  assign ch_count[0] = '0;
  assign ch_age[0]   = '0;
  assign ch_idx[0]   = '0;
  assign ch_key[0]   = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign cmd[i] = '{op: cell_op, sel: sel_vec[i]};

    lcl_cell #(
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS),
      .COUNT_BITS(COUNT_BITS),
      .IDX_W     (IDX_W),
      .INDEX     (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .req_key  (req_key),
      .req_data (req_data),
      .op_clock (op_clock),
      .cmd      (cmd[i]),
      .match    (match[i]),
      .rd_data  (rd_data[i]),
      .in_has   (ch_has[i]),
      .in_count (ch_count[i]),
      .in_age   (ch_age[i]),
      .in_idx   (ch_idx[i]),
      .in_key   (ch_key[i]),
      .out_has  (ch_has[i+1]),
      .out_count(ch_count[i+1]),
      .out_age  (ch_age[i+1]),
      .out_idx  (ch_idx[i+1]),
      .out_key  (ch_key[i+1])
    );
  end

  // keys are unique among valid entries, so an OR is a one-hot select
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rd_any = rd_any | rd_data[i];
    end
  end

  assign cap_eff    = (capacity == '0) ? CAP_W'(1) : capacity;
  assign evict_need = (used == OCC_W'(ENTRIES)) || (CMP_W'(used) >= CMP_W'(cap_eff));

  // entries fill in index order and never empty, so the free slot is 'used'
  always_comb begin
    if (hit_r) begin
      sel_vec = match_r;
    end else if (evict_r) begin
      sel_vec = ENTRIES'(1) << ch_idx[ENTRIES];
    end else begin
      sel_vec = ENTRIES'(1) << used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!(|match) && req_act == ACT_SET && evict_need) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    upd_go   = 1'b0;
    cell_op  = CELL_NOP;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_UPDATE: begin
        upd_go = !out_valid || !out_stall;
        if (upd_go) begin
          if (hit_r) begin
            cell_op = (req_act == ACT_SET) ? CELL_WRITE : CELL_RAISE;
          end else if (req_act == ACT_SET) begin
            cell_op = CELL_FILL;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_act  <= action_t'(action);
      req_key  <= key;
      req_data <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      hit_r   <= |match;
      match_r <= match;
      dout_r  <= rd_any;
      evict_r <= !(|match) && req_act == ACT_SET && evict_need;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      scan_cnt <= '0;
    end else if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RESET);
      used     <= '0;
      op_clock <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (upd_go) begin
        op_clock <= op_clock + STAMP_W'(1);
        if (!hit_r && req_act == ACT_SET && !evict_r) begin
          used <= used + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      hit         <= hit_r;
      data_out    <= (hit_r && req_act == ACT_GET) ? dout_r : '0;
      evicted     <= evict_r;
      evicted_key <= evict_r ? ch_key[ENTRIES] : '0;
    end
  end

endmodule

// File: rtl/lcl_checker.sv
module lcl_checker #(
  parameter int KEY_BITS  = lcl_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = lcl_pkg::DATA_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 hit,
  input logic [DATA_BITS-1:0] data_out,
  input logic                 evicted,
  input logic [KEY_BITS-1:0]  evicted_key
);

  // one request in flight: busy right after a transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a request is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit and eviction in one result");

  a_evkey_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_key == '0)
    else $error("evicted_key set without eviction");

  a_data_needs_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_out != '0 |-> hit)
    else $error("data_out set on a miss");

endmodule

bind lfu_cache_lookup_top lcl_checker #(
  .KEY_BITS (KEY_BITS),
  .DATA_BITS(DATA_BITS)
) u_lcl_checker (.*);

// File: test/lfu_lookup_checker.sv
module lfu_lookup_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                action,
  input  logic [lcl_pkg::KEY_BITS_DEF-1:0]    key,
  input  logic [lcl_pkg::DATA_BITS_DEF-1:0]   data_in,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                hit,
  input  logic [lcl_pkg::DATA_BITS_DEF-1:0]   data_out,
  input  logic                                evicted,
  input  logic [lcl_pkg::KEY_BITS_DEF-1:0]    evicted_key,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [lcl_pkg::CAP_W-1:0]           cfg_data,
  output int                                  fail_count,
  output int                                  owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import lcl_pkg::*;

  localparam int NSLOT = ENTRIES_DEF;
  localparam int KW    = KEY_BITS_DEF;
  localparam int DW    = DATA_BITS_DEF;
  localparam int CW    = COUNT_BITS_DEF;

  typedef struct packed {
    logic          hit;
    logic [DW-1:0] data;
    logic          evicted;
    logic [KW-1:0] victim_key;
  } lookup_result_t;

  logic                 ent_valid [NSLOT];
  logic [KW-1:0]        ent_key   [NSLOT];
  logic [DW-1:0]        ent_data  [NSLOT];
  logic [CW-1:0]        ent_uses  [NSLOT];
  logic [STAMP_W-1:0]   ent_stamp [NSLOT];
  logic [STAMP_W-1:0]   tick;
  logic [CAP_W-1:0]     cap_reg;

  lookup_result_t owed_q[$];
  lookup_result_t want;
  int errs = 0;

  // advances the cache image by one request and returns the expected result
  function automatic lookup_result_t model_lookup(action_t act, logic [KW-1:0] k,
                                                  logic [DW-1:0] d);
    lookup_result_t r;
    int cap, used, found, free_slot, s;
    logic [CW-1:0] bc;
    logic [STAMP_W-1:0] ba, age;
    r = '0;
    cap = int'(cap_reg);
    if (cap < 1) cap = 1;
    if (cap > NSLOT) cap = NSLOT;
    used = 0;
    found = -1;
    free_slot = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (ent_valid[i]) begin
        used++;
        if (found < 0 && ent_key[i] == k) found = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (act == ACT_GET) r.data = ent_data[found];
      else ent_data[found] = d;
      if (ent_uses[found] != '1) begin
        ent_uses[found]  = ent_uses[found] + 1'b1;
        ent_stamp[found] = tick;
      end
    end else if (act == ACT_SET) begin
      s = free_slot;
      if (used >= cap || s < 0) begin
        s = -1;
        bc = '0;
        ba = '0;
        for (int i = 0; i < NSLOT; i++) begin
          if (ent_valid[i]) begin
            age = tick - ent_stamp[i];
            if (s < 0 || ent_uses[i] < bc || (ent_uses[i] == bc && age > ba)) begin
              s  = i;
              bc = ent_uses[i];
              ba = age;
            end
          end
        end
        if (s >= 0) begin
          r.evicted    = 1'b1;
          r.victim_key = ent_key[s];
        end
      end
      if (s >= 0) begin
        ent_valid[s] = 1'b1;
        ent_key[s]   = k;
        ent_data[s]  = d;
        ent_uses[s]  = CW'(1);
        ent_stamp[s] = tick;
      end
    end
    tick = tick + 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) begin
        ent_valid[i] = 1'b0;
        ent_key[i]   = '0;
        ent_data[i]  = '0;
        ent_uses[i]  = '0;
        ent_stamp[i] = '0;
      end
      tick = '0;
      cap_reg = CAP_W'(CAP_RESET);
      owed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          errs++;
        end else begin
          want = owed_q[0];
          owed_q.delete(0);
          if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            errs++;
          end
          if (data_out !== want.data) begin
            $error("data_out: expected %h, got %h", want.data, data_out);
            errs++;
          end
          if (evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, evicted);
            errs++;
          end
          if (evicted_key !== want.victim_key) begin
            $error("evicted_key: expected %h, got %h", want.victim_key, evicted_key);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall)
        owed_q.insert(owed_q.size(), model_lookup(action_t'(action), key, data_in));
    end
    fail_count <= errs;
    owed <= owed_q.size();
  end

endmodule

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lcl_pkg::*;

  localparam int LIMIT  = 200000;
  localparam int SETTLE = ENTRIES_DEF + 6;
  localparam int RUN_GETS = 30;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     action = 1'b0;
  logic [KEY_BITS_DEF-1:0]  key = '0;
  logic [DATA_BITS_DEF-1:0] data_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     hit;
  logic [DATA_BITS_DEF-1:0] data_out;
  logic                     evicted;
  logic [KEY_BITS_DEF-1:0]  evicted_key;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         cfg_data = '0;

  int fail_count;
  int owed;
  int cycles = 0;
  bit idle_en = 1'b1;
  logic stall_en = 1'b1;

  lfu_cache_lookup_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key(key), .data_in(data_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .data_out(data_out), .evicted(evicted), .evicted_key(evicted_key),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  lfu_lookup_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key(key), .data_in(data_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .data_out(data_out), .evicted(evicted), .evicted_key(evicted_key),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .owed(owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= stall_en && ($urandom_range(99) < 17);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_req(action_t a, logic [KEY_BITS_DEF-1:0] k,
                          logic [DATA_BITS_DEF-1:0] d);
    while (idle_en && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= a;
    key      <= k;
    data_in  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every result is back and the victim search has settled
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [KEY_BITS_DEF-1:0] pool [24];
    logic [KEY_BITS_DEF-1:0] k;
    int pool_n;
    logic [CAP_W-1:0] cap;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: key/data extremes, set hit, age tie-break, capacity edges
    send_req(ACT_GET, '0, '1);
    send_req(ACT_SET, '0, '0);
    send_req(ACT_SET, '1, '1);
    send_req(ACT_GET, '0, '0);
    send_req(ACT_GET, '1, '0);
    send_req(ACT_SET, '0, 32'h1234_5678);
    send_req(ACT_GET, '0, '1);
    send_req(ACT_SET, 32'd5, 32'h5555_5555);
    send_req(ACT_SET, 32'd6, 32'h6666_6666);
    send_req(ACT_GET, 32'd7, 32'h7777_7777);
    set_capacity(5'd3);
    send_req(ACT_SET, 32'd8, 32'h8888_8888);
    send_req(ACT_SET, 32'd9, 32'h9999_9999);
    send_req(ACT_GET, 32'd5, '0);
    set_capacity(5'd0);
    send_req(ACT_SET, 32'd10, 32'hAAAA_AAAA);
    send_req(ACT_GET, 32'd10, '0);
    set_capacity(5'd31);
    send_req(ACT_SET, 32'd11, 32'hBBBB_BBBB);
    send_req(ACT_SET, 32'h8000_0000, 32'h8000_0001);
    send_req(ACT_GET, 32'h8000_0000, '0);
    send_req(ACT_SET, 32'd6, 32'h0F0F_0F0F);

    // back to back with no gaps
    drain();
    idle_en = 1'b0;
    stall_en <= 1'b0;
    send_req(ACT_SET, 32'hA5A5_5A5A, 32'hC3C3_3C3C);
    for (int i = 0; i < RUN_GETS; i++) send_req(ACT_GET, 32'hA5A5_5A5A, $urandom);
    drain();
    idle_en = 1'b1;
    stall_en <= 1'b1;

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: cap = 5'd1;
        1: cap = 5'd16;
        2: cap = 5'd0;
        3: cap = 5'd31;
        4: cap = 5'd2;
        default: cap = CAP_W'($urandom_range(31));
      endcase
      set_capacity(cap);
      idle_en = (ph != 5);
      stall_en <= (ph != 5);
      pool_n = $urandom_range(2, 24);
      for (int i = 0; i < 24; i++) pool[i] = $urandom;
      if ($urandom_range(3) == 0) pool[0] = '0;
      if ($urandom_range(3) == 0) pool[1] = '1;
      for (int n = 0; n < 105; n++) begin
        k = ($urandom_range(99) < 85) ? pool[$urandom_range(pool_n - 1)] : $urandom;
        send_req(action_t'($urandom_range(1)), k, $urandom);
      end
    end

    drain();
    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/lcl_pkg.sv
rtl/lcl_cell.sv
rtl/lfu_cache_lookup_top.sv
rtl/lcl_checker.sv
test/lfu_lookup_checker.sv
test/tb_top.sv
